FILE: hdl/tcpc_pkg.sv
// Shared types, codes and constants for the text console put-character core.
// Used by the channel interfaces and the top level.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tcpc_pkg;

   // Default geometry, handed to the top level parameters.
   localparam int DEF_SCREEN_COLUMNS = 80;
   localparam int DEF_SCREEN_ROWS    = 25;
   localparam int DEF_TAB_WIDTH      = 8;

   // Fixed field widths of the channels and the register port.
   localparam int OP_W        = 2;
   localparam int CHAR_W      = 8;
   localparam int ADDR_IN_W   = 11;
   localparam int COLUMN_W    = 7;
   localparam int ROW_W       = 5;
   localparam int LOC_W       = 11;
   localparam int CELL_W      = 16;
   localparam int COLOUR_W    = 4;
   localparam int CSR_INDEX_W = 1;

   typedef enum logic [OP_W-1:0] {
      OP_PUT   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FOREGROUND = 1'd0,
      CSR_BACKGROUND = 1'd1
   } csr_index_type;

   // Characters with special handling.
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

   // White on black space used by clear and scroll.
   localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

   localparam logic [COLOUR_W-1:0] FOREGROUND_RESET = 4'hF;
   localparam logic [COLOUR_W-1:0] BACKGROUND_RESET = 4'h0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SCROLL,
      ST_CLEAR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [COLUMN_W-1:0] cursor_column;
      logic [ROW_W-1:0]    cursor_row;
      logic [LOC_W-1:0]    cursor_location;
      logic [CELL_W-1:0]   cell_data;
   } result_type;

endpackage

`default_nettype wire

FILE: hdl/tcpc_req_if.sv
// Request channel of the text console core: valid/ready plus one item.
// Depends on tcpc_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tcpc_req_if;
   logic                          valid;
   logic                          ready;
   logic [tcpc_pkg::OP_W-1:0]      operation;
   logic [tcpc_pkg::CHAR_W-1:0]    character;
   logic [tcpc_pkg::ADDR_IN_W-1:0] cell_address;

   modport source (output valid, output operation, output character,
                   output cell_address, input ready);
   modport sink (input valid, input operation, input character,
                 input cell_address, output ready);
endinterface

`default_nettype wire

FILE: hdl/tcpc_rsp_if.sv
// Response channel of the text console core: valid/ready plus one result.
// Depends on tcpc_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tcpc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [tcpc_pkg::COLUMN_W-1:0] cursor_column;
   logic [tcpc_pkg::ROW_W-1:0]    cursor_row;
   logic [tcpc_pkg::LOC_W-1:0]    cursor_location;
   logic [tcpc_pkg::CELL_W-1:0]   cell_data;

   modport source (output valid, output cursor_column, output cursor_row,
                   output cursor_location, output cell_data, input ready);
   modport sink (input valid, input cursor_column, input cursor_row,
                 input cursor_location, input cell_data, output ready);
endinterface

`default_nettype wire

FILE: hdl/tcpc_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Holds the screen cells of the text console core; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tcpc_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 2000,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/text_console_put_char_core.sv
// Text console core: cell RAM, cursor and control-character handling.
// Flow: put without scroll and op 3 go idle, done; read goes idle, read, done;
// scroll and clear sweep the cell RAM one cell a cycle, then go to done.
// Requests are taken only in idle, once the previous result is in the output register.
// A new request is taken while the previous result still waits on the output.
// Reset: synchronous; cursor homed, colours white on black, cells undefined.
`timescale 1ns / 1ps
`default_nettype none

module text_console_put_char_core #(
   parameter int SCREEN_COLUMNS = tcpc_pkg::DEF_SCREEN_COLUMNS,
   parameter int SCREEN_ROWS    = tcpc_pkg::DEF_SCREEN_ROWS,
   parameter int TAB_WIDTH      = tcpc_pkg::DEF_TAB_WIDTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   tcpc_req_if.sink                               req_ch,
   tcpc_rsp_if.source                             rsp_ch,
   input  wire logic                              csr_wr_en,
   input  wire logic [tcpc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [tcpc_pkg::COLOUR_W-1:0]     csr_wr_data
);

   localparam int CELLS  = SCREEN_COLUMNS * SCREEN_ROWS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int CW     = $clog2(SCREEN_COLUMNS);
   localparam int CT     = $clog2(SCREEN_COLUMNS + TAB_WIDTH);
   localparam int RW     = $clog2(SCREEN_ROWS);
   localparam int RW1    = $clog2(SCREEN_ROWS + 1);
   localparam int PW     = $clog2(TAB_WIDTH);

   tcpc_pkg::state_type  state_ff, state_in;
   logic [CW-1:0]        col_ff, col_in;
   logic [RW-1:0]        row_ff, row_in;
   logic [PW-1:0]        phase_ff, phase_in;   // column modulo tab width
   logic [tcpc_pkg::COLOUR_W-1:0] fg_ff, bg_ff;
   logic [ADDR_W-1:0]    ptr_ff, ptr_in;
   logic                 sw_pend_ff, sw_pend_in;
   logic [ADDR_W-1:0]    sw_addr_ff, sw_addr_in;
   logic                 sw_blank_ff, sw_blank_in;
   logic                 rd_ok_ff, rd_ok_in;
   tcpc_pkg::result_type res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   tcpc_pkg::result_type rsp_data_ff, rsp_data_in;

   // Next cursor for a put.
   logic [CT-1:0]        col_t;
   logic [RW1-1:0]       row_t;
   logic [PW-1:0]        phase_t;
   logic [CW-1:0]        col_n;
   logic [RW-1:0]        row_n;
   logic                 print_en;
   logic                 scroll_n;
   logic [ADDR_W-1:0]    cur_idx;
   logic [ADDR_W-1:0]    loc_n;

   logic                 req_acc;
   tcpc_pkg::op_type     op;
   logic                 rsp_free;

   logic                 ram_wr_en;
   logic [ADDR_W-1:0]    ram_wr_addr;
   logic [tcpc_pkg::CELL_W-1:0] ram_wr_data;
   logic                 ram_rd_en;
   logic [ADDR_W-1:0]    ram_rd_addr;
   logic [tcpc_pkg::CELL_W-1:0] ram_rd_data;

   assign op       = tcpc_pkg::op_type'(req_ch.operation);
   assign req_acc  = req_ch.valid && req_ch.ready;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   assign cur_idx = ADDR_W'(row_ff) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(col_ff);
   assign loc_n   = ADDR_W'(row_n) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(col_n);

   always_comb begin
      col_t    = CT'(col_ff);
      row_t    = RW1'(row_ff);
      phase_t  = phase_ff;
      print_en = 1'b0;
      unique case (req_ch.character)
         tcpc_pkg::CH_BACKSPACE: begin
            if (col_ff != '0) begin
               col_t   = CT'(col_ff) - CT'(1);
               phase_t = (phase_ff == '0) ? PW'(TAB_WIDTH - 1) : phase_ff - PW'(1);
            end
         end
         tcpc_pkg::CH_TAB: begin
            col_t   = CT'(col_ff) + CT'(TAB_WIDTH) - CT'(phase_ff);
            phase_t = '0;
         end
         tcpc_pkg::CH_RETURN: begin
            col_t   = '0;
            phase_t = '0;
         end
         tcpc_pkg::CH_NEWLINE: begin
            col_t   = '0;
            phase_t = '0;
            row_t   = RW1'(row_ff) + RW1'(1);
         end
         default: begin
            // Bytes with the top bit set count as negative and are dropped.
            if (!req_ch.character[tcpc_pkg::CHAR_W-1] &&
                req_ch.character >= tcpc_pkg::CH_SPACE) begin
               print_en = 1'b1;
               col_t    = CT'(col_ff) + CT'(1);
               phase_t  = (phase_ff == PW'(TAB_WIDTH - 1)) ? '0 : phase_ff + PW'(1);
            end
         end
      endcase
      if (col_t >= CT'(SCREEN_COLUMNS)) begin
         col_t   = '0;
         phase_t = '0;
         row_t   = row_t + RW1'(1);
      end
      scroll_n = (row_t == RW1'(SCREEN_ROWS));
      col_n    = CW'(col_t);
      row_n    = scroll_n ? RW'(SCREEN_ROWS - 1) : RW'(row_t);
   end

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      phase_in     = phase_ff;
      ptr_in       = ptr_ff;
      sw_pend_in   = 1'b0;
      sw_addr_in   = sw_addr_ff;
      sw_blank_in  = sw_blank_ff;
      rd_ok_in     = rd_ok_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = ADDR_W'(req_ch.cell_address);
      req_ch.ready = 1'b0;

      unique case (state_ff)
         tcpc_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_acc) begin
               res_in.cursor_column   = tcpc_pkg::COLUMN_W'(col_ff);
               res_in.cursor_row      = tcpc_pkg::ROW_W'(row_ff);
               res_in.cursor_location = tcpc_pkg::LOC_W'(cur_idx);
               res_in.cell_data       = '0;
               ptr_in                 = '0;
               unique case (op)
                  tcpc_pkg::OP_PUT: begin
                     col_in   = col_n;
                     row_in   = row_n;
                     phase_in = phase_t;
                     res_in.cursor_column   = tcpc_pkg::COLUMN_W'(col_n);
                     res_in.cursor_row      = tcpc_pkg::ROW_W'(row_n);
                     res_in.cursor_location = tcpc_pkg::LOC_W'(loc_n);
                     state_in = scroll_n ? tcpc_pkg::ST_SCROLL : tcpc_pkg::ST_DONE;
                  end
                  tcpc_pkg::OP_CLEAR: begin
                     col_in   = '0;
                     row_in   = '0;
                     phase_in = '0;
                     res_in.cursor_column   = '0;
                     res_in.cursor_row      = '0;
                     res_in.cursor_location = '0;
                     state_in = tcpc_pkg::ST_CLEAR;
                  end
                  tcpc_pkg::OP_READ: begin
                     ram_rd_en = 1'b1;
                     rd_ok_in  = 32'(req_ch.cell_address) < 32'(CELLS);
                     state_in  = tcpc_pkg::ST_READ;
                  end
                  default: begin
                     state_in = tcpc_pkg::ST_DONE;
                  end
               endcase
            end
         end
         tcpc_pkg::ST_READ: begin
            res_in.cell_data = rd_ok_ff ? ram_rd_data : '0;
            state_in         = tcpc_pkg::ST_DONE;
         end
         tcpc_pkg::ST_SCROLL: begin
            // Read the cell one row below; it is written one row up next cycle.
            ram_rd_en   = 1'b1;
            ram_rd_addr = ptr_ff + ADDR_W'(SCREEN_COLUMNS);
            sw_pend_in  = 1'b1;
            sw_addr_in  = ptr_ff;
            sw_blank_in = !(ptr_ff < ADDR_W'(CELLS - SCREEN_COLUMNS));
            ptr_in      = ptr_ff + ADDR_W'(1);
            if (ptr_ff == ADDR_W'(CELLS - 1)) begin
               state_in = tcpc_pkg::ST_DONE;
            end
         end
         tcpc_pkg::ST_CLEAR: begin
            ptr_in = ptr_ff + ADDR_W'(1);
            if (ptr_ff == ADDR_W'(CELLS - 1)) begin
               state_in = tcpc_pkg::ST_DONE;
            end
         end
         tcpc_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = tcpc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tcpc_pkg::ST_IDLE;
         end
      endcase
   end

   // One write port: the delayed scroll copy, a printed character or the clear sweep.
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = ptr_ff;
      ram_wr_data = tcpc_pkg::BLANK_CELL;
      if (sw_pend_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = sw_addr_ff;
         ram_wr_data = sw_blank_ff ? tcpc_pkg::BLANK_CELL : ram_rd_data;
      end else if (req_acc && op == tcpc_pkg::OP_PUT && print_en) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = cur_idx;
         ram_wr_data = {bg_ff, fg_ff, req_ch.character};
      end else if (state_ff == tcpc_pkg::ST_CLEAR) begin
         ram_wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcpc_pkg::ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         phase_ff     <= '0;
         fg_ff        <= tcpc_pkg::FOREGROUND_RESET;
         bg_ff        <= tcpc_pkg::BACKGROUND_RESET;
         sw_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         phase_ff     <= phase_in;
         sw_pend_ff   <= sw_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (tcpc_pkg::csr_index_type'(csr_index))
               tcpc_pkg::CSR_FOREGROUND: fg_ff <= csr_wr_data;
               tcpc_pkg::CSR_BACKGROUND: bg_ff <= csr_wr_data;
               default: fg_ff <= fg_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      sw_addr_ff  <= sw_addr_in;
      sw_blank_ff <= sw_blank_in;
      rd_ok_ff    <= rd_ok_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   tcpc_ram #(
      .WIDTH  (tcpc_pkg::CELL_W),
      .DEPTH  (CELLS),
      .ADDR_W (ADDR_W)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.cursor_column   = rsp_data_ff.cursor_column;
   assign rsp_ch.cursor_row      = rsp_data_ff.cursor_row;
   assign rsp_ch.cursor_location = rsp_data_ff.cursor_location;
   assign rsp_ch.cell_data       = rsp_data_ff.cell_data;

   // The stored cursor always points inside the screen.
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (32'(col_ff) < SCREEN_COLUMNS) && (32'(row_ff) < SCREEN_ROWS))
      else $error("cursor outside the screen");

   // A delayed scroll write only follows a cycle of the scroll sweep.
   a_scroll_write: assert property (@(posedge clock) disable iff (reset)
      sw_pend_ff |-> $past(state_ff == tcpc_pkg::ST_SCROLL))
      else $error("scroll write without a scroll read");

   // A clear starts its sweep with the cursor homed.
   a_clear_home: assert property (@(posedge clock) disable iff (reset)
      (req_acc && op == tcpc_pkg::OP_CLEAR) |=>
      (state_ff == tcpc_pkg::ST_CLEAR && col_ff == '0 && row_ff == '0 && ptr_ff == '0))
      else $error("clear did not home the cursor");

   // A finished result waits while the output register is still occupied.
   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcpc_pkg::ST_DONE && rsp_valid_ff && !rsp_ch.ready) |=>
      (state_ff == tcpc_pkg::ST_DONE && rsp_valid_ff))
      else $error("result overwrote a pending transfer");

endmodule

`default_nettype wire
